@@ rtl/ttf_pkg.sv @@
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared types, constants and the product schedule of the tangent frame block.
// ----------------------------------------------------------------------------
package ttf_pkg;

	localparam int POS_WIDTH_DEF  = 32;
	localparam int UNIT_FRAC_DEF  = 14;
	localparam int UV_WIDTH       = 18;
	localparam int OUT_WIDTH      = 16;
	localparam int CHUNK          = 16;   // multiplier slice of operand b
	localparam int MAG_W          = 31;   // scaled magnitude width
	localparam int SUM_W          = 64;
	localparam int ROOT_W         = 32;
	localparam int ROOT_STEPS     = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int OPERANDS       = 10;
	localparam int NPROD          = 20;
	localparam int COMPS          = 10;
	localparam int RESULTS        = 9;

	// operand register codes
	typedef enum logic [3:0] {
		OP_AB_X, OP_AB_Y, OP_AB_Z,
		OP_AC_X, OP_AC_Y, OP_AC_Z,
		OP_D1U, OP_D1V, OP_D2U, OP_D2V
	} opnd_t;

	// component slots: determinant, tangent, bitangent, normal
	localparam logic [3:0] COMP_DET = 4'd0;
	localparam logic [3:0] COMP_TAN = 4'd1;
	localparam logic [3:0] COMP_BIT = 4'd4;
	localparam logic [3:0] COMP_NRM = 4'd7;

	typedef struct packed {
		opnd_t      a;
		opnd_t      b;
		logic       neg;   // second term of a difference
		logic       flip;  // follows the sign of the determinant
		logic [3:0] dst;
	} prod_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_DRAIN, ST_VSTART, ST_LEN, ST_SCALE, ST_SQUARE,
		ST_SQRT, ST_DIV_LOAD, ST_DIV, ST_EMIT, ST_NEXT, ST_OUT
	} back_st_t;

	function automatic prod_t prod_entry(input logic [4:0] idx);
		prod_t p;
		case (idx)
			5'd0:  p = '{OP_D1U,  OP_D2V,  1'b0, 1'b0, COMP_DET};
			5'd1:  p = '{OP_D2U,  OP_D1V,  1'b1, 1'b0, COMP_DET};
			5'd2:  p = '{OP_AB_X, OP_D2V,  1'b0, 1'b1, COMP_TAN};
			5'd3:  p = '{OP_AC_X, OP_D1V,  1'b1, 1'b1, COMP_TAN};
			5'd4:  p = '{OP_AB_Y, OP_D2V,  1'b0, 1'b1, COMP_TAN + 4'd1};
			5'd5:  p = '{OP_AC_Y, OP_D1V,  1'b1, 1'b1, COMP_TAN + 4'd1};
			5'd6:  p = '{OP_AB_Z, OP_D2V,  1'b0, 1'b1, COMP_TAN + 4'd2};
			5'd7:  p = '{OP_AC_Z, OP_D1V,  1'b1, 1'b1, COMP_TAN + 4'd2};
			5'd8:  p = '{OP_AC_X, OP_D1U,  1'b0, 1'b1, COMP_BIT};
			5'd9:  p = '{OP_AB_X, OP_D2U,  1'b1, 1'b1, COMP_BIT};
			5'd10: p = '{OP_AC_Y, OP_D1U,  1'b0, 1'b1, COMP_BIT + 4'd1};
			5'd11: p = '{OP_AB_Y, OP_D2U,  1'b1, 1'b1, COMP_BIT + 4'd1};
			5'd12: p = '{OP_AC_Z, OP_D1U,  1'b0, 1'b1, COMP_BIT + 4'd2};
			5'd13: p = '{OP_AB_Z, OP_D2U,  1'b1, 1'b1, COMP_BIT + 4'd2};
			5'd14: p = '{OP_AB_Y, OP_AC_Z, 1'b0, 1'b0, COMP_NRM};
			5'd15: p = '{OP_AB_Z, OP_AC_Y, 1'b1, 1'b0, COMP_NRM};
			5'd16: p = '{OP_AB_Z, OP_AC_X, 1'b0, 1'b0, COMP_NRM + 4'd1};
			5'd17: p = '{OP_AB_X, OP_AC_Z, 1'b1, 1'b0, COMP_NRM + 4'd1};
			5'd18: p = '{OP_AB_X, OP_AC_Y, 1'b0, 1'b0, COMP_NRM + 4'd2};
			5'd19: p = '{OP_AB_Y, OP_AC_X, 1'b1, 1'b0, COMP_NRM + 4'd2};
			default: p = '{OP_D1U, OP_D2V, 1'b0, 1'b0, COMP_DET};
		endcase
		return p;
	endfunction

endpackage

@@ rtl/ttf_if.sv @@
// ----------------------------------------------------------------------------
// ttf channel interfaces
// Vertex input channel and frame result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ttf_vtx_if import ttf_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] pos_x;
	logic signed [POS_WIDTH-1:0] pos_y;
	logic signed [POS_WIDTH-1:0] pos_z;
	logic signed [UV_WIDTH-1:0]  tex_u;
	logic signed [UV_WIDTH-1:0]  tex_v;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttf_frame_if import ttf_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic signed [OUT_WIDTH-1:0] tan_x;
	logic signed [OUT_WIDTH-1:0] tan_y;
	logic signed [OUT_WIDTH-1:0] tan_z;
	logic signed [OUT_WIDTH-1:0] bitan_x;
	logic signed [OUT_WIDTH-1:0] bitan_y;
	logic signed [OUT_WIDTH-1:0] bitan_z;
	logic signed [OUT_WIDTH-1:0] norm_x;
	logic signed [OUT_WIDTH-1:0] norm_y;
	logic signed [OUT_WIDTH-1:0] norm_z;
	logic                        uv_degenerate;
	logic                        area_degenerate;

	modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
		norm_x, norm_y, norm_z, uv_degenerate, area_degenerate, input ready);
	modport sink   (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
		norm_x, norm_y, norm_z, uv_degenerate, area_degenerate, output ready);
endinterface

@@ rtl/ttf_front.sv @@
// ----------------------------------------------------------------------------
// ttf_front
// Takes vertices, holds the first two and forms edges and UV deltas on the third.
// ----------------------------------------------------------------------------
module ttf_front import ttf_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	localparam int EW     = POS_WIDTH + 1,
	localparam int DW     = UV_WIDTH + 1,
	localparam int ITEM_W = 6 * EW + 4 * DW
) (
	input  logic              clk,
	input  logic              arst_n,
	ttf_vtx_if.sink           vtx,
	output logic              push,
	output logic [ITEM_W-1:0] item,
	input  logic              space
);

	logic [1:0]                  slot_q;
	logic signed [POS_WIDTH-1:0] a_pos_q [3];
	logic signed [POS_WIDTH-1:0] b_pos_q [3];
	logic signed [UV_WIDTH-1:0]  a_uv_q  [2];
	logic signed [UV_WIDTH-1:0]  b_uv_q  [2];
	logic signed [POS_WIDTH-1:0] cur_pos [3];
	logic signed [EW-1:0]        ab [3];
	logic signed [EW-1:0]        ac [3];
	logic signed [DW-1:0]        d1u, d1v, d2u, d2v;
	logic                        take;

	// a slot code of two or three counts as the closing vertex
	assign vtx.ready = !slot_q[1] || space;
	assign take      = vtx.valid && vtx.ready;
	assign push      = take && slot_q[1];

	always_comb begin
		cur_pos[0] = vtx.pos_x;
		cur_pos[1] = vtx.pos_y;
		cur_pos[2] = vtx.pos_z;
		for (int i = 0; i < 3; i++) begin
			ab[i] = EW'(b_pos_q[i]) - EW'(a_pos_q[i]);
			ac[i] = EW'(cur_pos[i]) - EW'(a_pos_q[i]);
		end
		d1u = DW'(b_uv_q[0]) - DW'(a_uv_q[0]);
		d1v = DW'(b_uv_q[1]) - DW'(a_uv_q[1]);
		d2u = DW'(vtx.tex_u) - DW'(a_uv_q[0]);
		d2v = DW'(vtx.tex_v) - DW'(a_uv_q[1]);
		item = {ab[0], ab[1], ab[2], ac[0], ac[1], ac[2], d1u, d1v, d2u, d2v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 2'd0;
		end else if (take) begin
			slot_q <= slot_q[1] ? 2'd0 : slot_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && slot_q == 2'd0) begin
			for (int i = 0; i < 3; i++) a_pos_q[i] <= cur_pos[i];
			a_uv_q[0] <= vtx.tex_u;
			a_uv_q[1] <= vtx.tex_v;
		end
		if (take && slot_q == 2'd1) begin
			for (int i = 0; i < 3; i++) b_pos_q[i] <= cur_pos[i];
			b_uv_q[0] <= vtx.tex_u;
			b_uv_q[1] <= vtx.tex_v;
		end
	end

endmodule

@@ rtl/ttf_queue.sv @@
// ----------------------------------------------------------------------------
// ttf_queue
// Short FIFO of triangle work items between the front and the back.
// ----------------------------------------------------------------------------
module ttf_queue import ttf_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             space,
	input  logic             pop,
	output logic             avail,
	output logic [WIDTH-1:0] head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_push, do_pop;

	assign space   = cnt_q != CNTW'(QUEUE_DEPTH);
	assign avail   = cnt_q != '0;
	assign head    = mem_q[rd_q];
	assign do_push = push && space;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CNTW'(do_push) - CNTW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule

@@ rtl/ttf_back.sv @@
// ----------------------------------------------------------------------------
// ttf_back
// Forms the frame vectors with one shared multiplier and normalises them.
// ----------------------------------------------------------------------------
module ttf_back import ttf_pkg::*; #(
	parameter int POS_WIDTH      = POS_WIDTH_DEF,
	parameter int UNIT_FRAC_BITS = UNIT_FRAC_DEF,
	localparam int EW     = POS_WIDTH + 1,
	localparam int DW     = UV_WIDTH + 1,
	localparam int ITEM_W = 6 * EW + 4 * DW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              avail,
	input  logic [ITEM_W-1:0] head,
	output logic              pop,
	ttf_frame_if.source       frame
);

	localparam int OPW   = (EW > DW) ? EW : DW;
	localparam int CW    = 2 * OPW + 1;
	localparam int PRW   = OPW + CHUNK;
	localparam int NCH_E = (EW + CHUNK - 1) / CHUNK;
	localparam int NCH_U = (DW + CHUNK - 1) / CHUNK;
	localparam int CHW   = $clog2(NCH_E);
	localparam int LW    = $clog2(CW + 1);
	localparam int QW    = UNIT_FRAC_BITS + 2;
	localparam int NUMW  = MAG_W + UNIT_FRAC_BITS + 1;
	localparam int DVW   = NUMW + 1;

	back_st_t state_q, state_d;

	logic signed [OPW-1:0] op_q [OPERANDS];
	logic [4:0]            pidx_q;
	logic [CHW-1:0]        chunk_q;
	logic [PRW-1:0]        p_s1;
	logic [CHW-1:0]        sh_s1;
	logic                  v_s1, sgn_s1, flip_s1, clr_s1, last_s1;
	logic [3:0]            dst_s1;
	logic signed [CW-1:0]  acc_q;
	logic signed [CW-1:0]  comp_q [COMPS];

	logic [1:0]            vidx_q, idx_q;
	logic [4:0]            iter_q;
	logic [CW-1:0]         mag_q [3];
	logic                  neg_q [3];
	logic [CW-1:0]         w_q;
	logic [LW-1:0]         len_q;
	logic [MAG_W-1:0]      m_q [3];
	logic [2*MAG_W-1:0]    sq_q;
	logic [SUM_W-1:0]      sum_q, v_q, r_q, bit_q;
	logic [ROOT_W-1:0]     n_q;
	logic [NUMW-1:0]       numer_q;
	logic [DVW-1:0]        dv_q;
	logic [QW-1:0]         q_q;
	logic                  zero_q, area_q;
	logic [OUT_WIDTH-1:0]  res_q [RESULTS];

	// multiplier issue
	prod_t                 pe;
	logic signed [OPW-1:0] opa, opb;
	logic [OPW-1:0]        ma, mb;
	logic [CHUNK-1:0]      mchunk;
	logic                  b_uv, last_chunk;
	// accumulate
	logic [CW-1:0]         term;
	logic                  tsgn;
	logic signed [CW-1:0]  acc_next;
	// normalise
	logic [CW-1:0]         vmag [3];
	logic [CW-1:0]         vor;
	logic                  det_zero, vec_skip;
	logic [MAG_W-1:0]      scaled, sq_src;
	logic [SUM_W-1:0]      rb;
	logic                  root_ge, div_ge;
	logic [QW-1:0]         qc;
	logic [31:0]           qx, qs;
	logic                  out_free;

	function automatic logic signed [OPW-1:0] pick(input opnd_t s,
			input logic signed [OPW-1:0] v [OPERANDS]);
		logic signed [OPW-1:0] r;
		case (s)
			OP_AB_X: r = v[0];
			OP_AB_Y: r = v[1];
			OP_AB_Z: r = v[2];
			OP_AC_X: r = v[3];
			OP_AC_Y: r = v[4];
			OP_AC_Z: r = v[5];
			OP_D1U:  r = v[6];
			OP_D1V:  r = v[7];
			OP_D2U:  r = v[8];
			OP_D2V:  r = v[9];
			default: r = v[0];
		endcase
		return r;
	endfunction

	always_comb begin
		pe     = prod_entry(pidx_q);
		opa    = pick(pe.a, op_q);
		opb    = pick(pe.b, op_q);
		ma     = opa[OPW-1] ? OPW'(-opa) : OPW'(opa);
		mb     = opb[OPW-1] ? OPW'(-opb) : OPW'(opb);
		mchunk = CHUNK'(mb >> (int'(chunk_q) * CHUNK));
		b_uv   = pe.b inside {OP_D1U, OP_D1V, OP_D2U, OP_D2V};
		last_chunk = b_uv ? (chunk_q == CHW'(NCH_U - 1)) : (chunk_q == CHW'(NCH_E - 1));

		term     = CW'(p_s1) << (int'(sh_s1) * CHUNK);
		tsgn     = sgn_s1 ^ (flip_s1 & comp_q[COMP_DET][CW-1]);
		acc_next = (clr_s1 ? '0 : acc_q) + (tsgn ? -term : term);

		for (int i = 0; i < 3; i++)
			vmag[i] = comp_q[1 + i][CW-1] ? CW'(-comp_q[1 + i]) : CW'(comp_q[1 + i]);
		vor      = vmag[0] | vmag[1] | vmag[2];
		det_zero = comp_q[COMP_DET] == '0;
		vec_skip = (vidx_q != 2'd2) && det_zero;

		if (int'(len_q) > MAG_W) scaled = MAG_W'(mag_q[idx_q] >> (int'(len_q) - MAG_W));
		else                     scaled = MAG_W'(mag_q[idx_q] << (MAG_W - int'(len_q)));

		case (idx_q)
			2'd0:    sq_src = m_q[0];
			2'd1:    sq_src = m_q[1];
			default: sq_src = m_q[2];
		endcase

		rb      = r_q + bit_q;
		root_ge = v_q >= rb;
		div_ge  = DVW'(numer_q) >= dv_q;

		qc = (q_q > (QW'(1) << UNIT_FRAC_BITS)) ? (QW'(1) << UNIT_FRAC_BITS) : q_q;
		qx = 32'(qc);
		qs = neg_q[idx_q] ? -qx : qx;

		out_free = !frame.valid || frame.ready;
	end

	assign pop = (state_q == ST_IDLE) && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (avail) state_d = ST_MUL;
			ST_MUL:      if (last_chunk && pidx_q == 5'(NPROD - 1)) state_d = ST_DRAIN;
			ST_DRAIN:    state_d = ST_VSTART;
			ST_VSTART:   state_d = (vec_skip || vor == '0) ? ST_EMIT : ST_LEN;
			ST_LEN:      if (w_q[CW-1]) state_d = ST_SCALE;
			ST_SCALE:    if (idx_q == 2'd2) state_d = ST_SQUARE;
			ST_SQUARE:   if (idx_q == 2'd3) state_d = ST_SQRT;
			ST_SQRT:     if (iter_q == 5'(ROOT_STEPS - 1)) state_d = ST_DIV_LOAD;
			ST_DIV_LOAD: state_d = ST_DIV;
			ST_DIV:      if (iter_q == 5'(QW - 1)) state_d = ST_EMIT;
			ST_EMIT: begin
				if (idx_q == 2'd2) state_d = ST_NEXT;
				else               state_d = zero_q ? ST_EMIT : ST_DIV_LOAD;
			end
			ST_NEXT:     state_d = (vidx_q == 2'd2) ? ST_OUT : ST_VSTART;
			ST_OUT:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			frame.valid <= 1'b0;
		end else begin
			v_s1 <= state_q == ST_MUL;
			if (state_q == ST_OUT && out_free) frame.valid <= 1'b1;
			else if (frame.ready)              frame.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		// product issue: one slice of operand b a cycle
		p_s1    <= PRW'(ma) * PRW'(mchunk);
		sh_s1   <= chunk_q;
		sgn_s1  <= opa[OPW-1] ^ opb[OPW-1] ^ pe.neg;
		flip_s1 <= pe.flip;
		clr_s1  <= !pe.neg && chunk_q == '0;
		last_s1 <= pe.neg && last_chunk;
		dst_s1  <= pe.dst;
		if (v_s1) begin
			acc_q <= acc_next;
			if (last_s1) comp_q[dst_s1] <= acc_next;
		end

		case (state_q)
			ST_IDLE: begin
				for (int k = 0; k < 6; k++)
					op_q[k] <= OPW'($signed(head[ITEM_W-1-k*EW -: EW]));
				for (int k = 0; k < 4; k++)
					op_q[6 + k] <= OPW'($signed(head[4*DW-1-k*DW -: DW]));
				pidx_q  <= '0;
				chunk_q <= '0;
				vidx_q  <= '0;
			end
			ST_MUL: begin
				if (last_chunk) begin
					chunk_q <= '0;
					pidx_q  <= pidx_q + 5'd1;
				end else begin
					chunk_q <= chunk_q + 1'b1;
				end
			end
			ST_VSTART: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= vmag[i];
					neg_q[i] <= comp_q[1 + i][CW-1];
				end
				w_q    <= vor;
				len_q  <= LW'(CW);
				zero_q <= vec_skip || vor == '0;
				idx_q  <= '0;
				if (vidx_q == 2'd2) area_q <= vor == '0;
			end
			ST_LEN: begin
				// find the bit length: a byte at a time while the top byte is clear, else a bit at a time
				if (!w_q[CW-1]) begin
					if (w_q[CW-1 -: 8] == '0) begin
						w_q   <= w_q << 8;
						len_q <= len_q - LW'(8);
					end else begin
						w_q   <= w_q << 1;
						len_q <= len_q - LW'(1);
					end
				end
				idx_q <= '0;
			end
			ST_SCALE: begin
				m_q[idx_q] <= scaled;
				idx_q      <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				sum_q      <= '0;
			end
			ST_SQUARE: begin
				if (idx_q != 2'd3) sq_q <= sq_src * sq_src;
				if (idx_q != 2'd0) sum_q <= sum_q + SUM_W'(sq_q);
				idx_q  <= idx_q + 2'd1;
				v_q    <= sum_q + SUM_W'(sq_q);
				r_q    <= '0;
				bit_q  <= SUM_W'(1) << (SUM_W - 2);
				iter_q <= '0;
			end
			ST_SQRT: begin
				if (root_ge) begin
					v_q <= v_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				iter_q <= iter_q + 5'd1;
				if (root_ge) n_q <= ROOT_W'((r_q >> 1) + bit_q);
				else         n_q <= ROOT_W'(r_q >> 1);
				idx_q <= '0;
			end
			ST_DIV_LOAD: begin
				numer_q <= (NUMW'(m_q[idx_q]) << UNIT_FRAC_BITS) + NUMW'(n_q >> 1);
				dv_q    <= DVW'(n_q) << (QW - 1);
				q_q     <= '0;
				iter_q  <= '0;
			end
			ST_DIV: begin
				if (div_ge) numer_q <= NUMW'(DVW'(numer_q) - dv_q);
				q_q    <= {q_q[QW-2:0], div_ge};
				dv_q   <= dv_q >> 1;
				iter_q <= iter_q + 5'd1;
			end
			ST_EMIT: begin
				for (int k = 0; k < RESULTS - 1; k++) res_q[k] <= res_q[k + 1];
				res_q[RESULTS-1] <= zero_q ? '0 : qs[OUT_WIDTH-1:0];
				idx_q <= idx_q + 2'd1;
			end
			ST_NEXT: begin
				// move the next vector into the working slots
				for (int k = 1; k < 7; k++) comp_q[k] <= comp_q[k + 3];
				vidx_q <= vidx_q + 2'd1;
			end
			default: begin
			end
		endcase

		if (state_q == ST_OUT && out_free) begin
			frame.tan_x           <= res_q[0];
			frame.tan_y           <= res_q[1];
			frame.tan_z           <= res_q[2];
			frame.bitan_x         <= res_q[3];
			frame.bitan_y         <= res_q[4];
			frame.bitan_z         <= res_q[5];
			frame.norm_x          <= res_q[6];
			frame.norm_y          <= res_q[7];
			frame.norm_z          <= res_q[8];
			frame.uv_degenerate   <= det_zero;
			frame.area_degenerate <= area_q;
		end
	end

endmodule

@@ rtl/triangle_tangent_frame.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_frame
// Unit tangent, bitangent and face normal of one textured triangle.
// ----------------------------------------------------------------------------
// Feed the vertices of each triangle in order A, B, C; one frame beat comes
// out per triangle. A and B are taken as soon as they are offered. C is taken
// as soon as the two-entry work queue has room, and the triangle then occupies
// the back end: products on the shared magnitude-by-16-bit multiplier (at the
// default widths two slices for a UV operand, three for an edge), then for each
// nonzero vector a leading-one search, a 32-step square root and three divisions
// of UNIT_FRAC_BITS+2 steps each. The square root and divider take most of its
// time. A finished frame sits in the output register while the back end starts
// on the next triangle from the queue.
// A zero UV determinant gives zero tangent and bitangent with uv_degenerate
// set; a zero cross product gives a zero normal with area_degenerate set.
// ----------------------------------------------------------------------------
module triangle_tangent_frame import ttf_pkg::*; #(
	parameter int POS_WIDTH      = POS_WIDTH_DEF,
	parameter int UNIT_FRAC_BITS = UNIT_FRAC_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ttf_vtx_if.sink     vtx,
	ttf_frame_if.source frame
);

	localparam int EW     = POS_WIDTH + 1;
	localparam int DW     = UV_WIDTH + 1;
	localparam int ITEM_W = 6 * EW + 4 * DW;

	logic              push, space, avail, pop;
	logic [ITEM_W-1:0] item, head;

	// front: hold A and B, form edges and UV deltas with C
	ttf_front #(
		.POS_WIDTH(POS_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.vtx   (vtx),
		.push  (push),
		.item  (item),
		.space (space)
	);

	// decouple the front from the long back end
	ttf_queue #(
		.WIDTH(ITEM_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(item),
		.space    (space),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	// back: products, normalisation and the output register
	ttf_back #(
		.POS_WIDTH     (POS_WIDTH),
		.UNIT_FRAC_BITS(UNIT_FRAC_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.avail (avail),
		.head  (head),
		.pop   (pop),
		.frame (frame)
	);

endmodule

@@ rtl/ttf_checker.sv @@
// ----------------------------------------------------------------------------
// ttf_checker
// Port-level checks on the frame channel of the tangent frame block.
// ----------------------------------------------------------------------------
module ttf_checker import ttf_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic signed [OUT_WIDTH-1:0] tan_x,
	input logic signed [OUT_WIDTH-1:0] tan_y,
	input logic signed [OUT_WIDTH-1:0] tan_z,
	input logic signed [OUT_WIDTH-1:0] bitan_x,
	input logic signed [OUT_WIDTH-1:0] bitan_y,
	input logic signed [OUT_WIDTH-1:0] bitan_z,
	input logic signed [OUT_WIDTH-1:0] norm_x,
	input logic signed [OUT_WIDTH-1:0] norm_y,
	input logic signed [OUT_WIDTH-1:0] norm_z,
	input logic                        uv_degenerate,
	input logic                        area_degenerate
);

	// hold a stalled beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({tan_x, tan_y, tan_z,
			bitan_x, bitan_y, bitan_z, norm_x, norm_y, norm_z,
			uv_degenerate, area_degenerate}))
		else $error("frame beat changed while stalled");

	a_uv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && uv_degenerate |-> tan_x == '0 && tan_y == '0 && tan_z == '0
			&& bitan_x == '0 && bitan_y == '0 && bitan_z == '0)
		else $error("uv degenerate frame with nonzero tangent");

	a_area_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && area_degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
		else $error("area degenerate frame with nonzero normal");

	// a nonzero cross product always normalises to a nonzero unit vector
	a_norm_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !area_degenerate |-> norm_x != '0 || norm_y != '0 || norm_z != '0)
		else $error("normal lost on a proper triangle");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (frame.valid),
	.out_ready      (frame.ready),
	.tan_x          (frame.tan_x),
	.tan_y          (frame.tan_y),
	.tan_z          (frame.tan_z),
	.bitan_x        (frame.bitan_x),
	.bitan_y        (frame.bitan_y),
	.bitan_z        (frame.bitan_z),
	.norm_x         (frame.norm_x),
	.norm_y         (frame.norm_y),
	.norm_z         (frame.norm_z),
	.uv_degenerate  (frame.uv_degenerate),
	.area_degenerate(frame.area_degenerate)
);

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the tangent frame block against a bit-exact predictor. A directed
// stimulus table covers extremes and the degenerate triangles, then random
// triangles follow, with random idling on the vertex and frame channels.
// ----------------------------------------------------------------------------
module tb;
	import ttf_pkg::*;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [17:0] u, v;
	} vertex_t;

	typedef struct {
		logic [15:0] t[3];
		logic [15:0] b[3];
		logic [15:0] n[3];
		logic        uvd, ard;
	} frame_t;

	// one row of the directed table; has_exp marks rows whose result is typed in
	typedef struct {
		vertex_t v;
		bit      has_exp;
		frame_t  exp;
	} row_t;

	localparam int RAND_TRIS = 295;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ttf_vtx_if   vtx();
	ttf_frame_if frame();

	triangle_tangent_frame DUT (.clk(clk), .arst_n(arst_n), .vtx(vtx), .frame(frame));

	always #2 clk = ~clk;

	// predictor state: held vertices A and B, and the vertex count
	vertex_t held_a, held_b;
	int      vtx_count;

	frame_t frames_due[$];
	int     mismatches = 0;
	int     frames_seen = 0;
	int     vtx_sent = 0;
	bit     calm = 1'b0;
	bit     drive_done = 1'b0;

	// Unit vector: scale so the longest magnitude has 31 bits, round-divide by
	// the integer root of the sum of squares, clamp at one.
	function automatic void to_unit(input logic signed [127:0] c[3],
			output logic [15:0] o[3]);
		logic [127:0] mg[3];
		logic [63:0]  m[3];
		logic [63:0]  sum, root, rem, q, bitv, one;
		int           len, l;
		len = 0;
		one = 64'd1 << UNIT_FRAC_DEF;
		for (int i = 0; i < 3; i++) begin
			mg[i] = c[i] < 0 ? -c[i] : c[i];
			l = 0;
			for (int k = 0; k < 128; k++) if (mg[i][k]) l = k + 1;
			if (l > len) len = l;
		end
		if (len == 0) begin
			for (int i = 0; i < 3; i++) o[i] = '0;
			return;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = len <= 31 ? 64'(mg[i] << (31 - len)) : 64'(mg[i] >> (len - 31));
			sum += m[i] * m[i];
		end
		root = 0;
		rem = sum;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else
				root >>= 1;
			bitv >>= 2;
		end
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << UNIT_FRAC_DEF) + (root >> 1)) / root;
			if (q > one) q = one;
			if (c[i] < 0) q = -q;
			o[i] = q[15:0];
		end
	endfunction

	// Frame of triangle A, B, C in 128-bit arithmetic.
	function automatic frame_t tbn_frame(input vertex_t a, input vertex_t b, input vertex_t c);
		frame_t f;
		logic signed [127:0] ab[3], ac[3], tv[3], bv[3], nv[3];
		logic signed [127:0] d1u, d1v, d2u, d2v, det;
		ab[0] = 128'(b.px) - 128'(a.px); ac[0] = 128'(c.px) - 128'(a.px);
		ab[1] = 128'(b.py) - 128'(a.py); ac[1] = 128'(c.py) - 128'(a.py);
		ab[2] = 128'(b.pz) - 128'(a.pz); ac[2] = 128'(c.pz) - 128'(a.pz);
		d1u = 128'(b.u) - 128'(a.u); d1v = 128'(b.v) - 128'(a.v);
		d2u = 128'(c.u) - 128'(a.u); d2v = 128'(c.v) - 128'(a.v);
		det = d1u * d2v - d2u * d1v;
		for (int i = 0; i < 3; i++) begin
			tv[i] = ab[i] * d2v - ac[i] * d1v;
			bv[i] = ac[i] * d1u - ab[i] * d2u;
			if (det < 0) begin
				tv[i] = -tv[i];
				bv[i] = -bv[i];
			end
		end
		nv[0] = ab[1] * ac[2] - ab[2] * ac[1];
		nv[1] = ab[2] * ac[0] - ab[0] * ac[2];
		nv[2] = ab[0] * ac[1] - ab[1] * ac[0];
		if (det == 0) begin
			for (int i = 0; i < 3; i++) begin
				f.t[i] = '0;
				f.b[i] = '0;
			end
			f.uvd = 1'b1;
		end else begin
			to_unit(tv, f.t);
			to_unit(bv, f.b);
			f.uvd = 1'b0;
		end
		to_unit(nv, f.n);
		f.ard = (nv[0] == 0 && nv[1] == 0 && nv[2] == 0);
		return f;
	endfunction

	// Advance the predictor by one accepted vertex beat.
	task automatic take_vertex(input vertex_t v);
		if (vtx_count == 0) begin
			held_a = v;
			vtx_count = 1;
		end else if (vtx_count == 1) begin
			held_b = v;
			vtx_count = 2;
		end else begin
			frames_due.push_back(tbn_frame(held_a, held_b, v));
			vtx_count = 0;
		end
	endtask

	function automatic vertex_t mk(input logic [31:0] x, y, z, input logic [17:0] u, v);
		vertex_t r;
		r.px = x; r.py = y; r.pz = z; r.u = u; r.v = v;
		return r;
	endfunction

	function automatic frame_t mkf(input logic [15:0] t0, t1, t2, b0, b1, b2,
			n0, n1, n2, input logic uvd, ard);
		frame_t f;
		f.t = '{t0, t1, t2}; f.b = '{b0, b1, b2}; f.n = '{n0, n1, n2};
		f.uvd = uvd; f.ard = ard;
		return f;
	endfunction

	// Random field value biased towards extremes and small numbers.
	function automatic logic [31:0] rnd_field(input int w);
		logic [31:0] r;
		case ($urandom_range(0, 5))
			0: r = 32'(1) << (w - 1);
			1: r = ~(32'(1) << (w - 1));
			2: r = 32'($urandom_range(0, 64)) - 32;
			3: r = $urandom >> $urandom_range(0, 31);
			default: r = $urandom;
		endcase
		return w == 32 ? r : 32'($signed(r[17:0]));
	endfunction

	function automatic vertex_t rnd_vertex();
		logic [31:0] u, v;
		u = rnd_field(UV_WIDTH);
		v = rnd_field(UV_WIDTH);
		return mk(rnd_field(32), rnd_field(32), rnd_field(32), u[17:0], v[17:0]);
	endfunction

	// Hold the vertex on the channel until the beat is taken; drop valid only
	// for an idle burst, so back-to-back beats keep it high.
	task automatic send(input vertex_t v);
		vtx.pos_x <= v.px; vtx.pos_y <= v.py; vtx.pos_z <= v.pz;
		vtx.tex_u <= v.u;  vtx.tex_v <= v.v;
		vtx.valid <= 1'b1;
		@(posedge clk);
		while (!vtx.ready) @(posedge clk);
		take_vertex(v);
		vtx_sent++;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			vtx.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	task automatic report(input string what, input logic [15:0] e, a);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch on frame %0d %s: expected %h, got %h", frames_seen, what, e, a);
	endtask

	// Frame side: random stalls, compare each beat with the oldest frame due.
	initial begin
		frame_t e;
		frame_t got;
		frame.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				frame.ready <= 1'b0;
				repeat ($urandom_range(1, 5) - 1) @(negedge clk);
			end else
				frame.ready <= 1'b1;
			@(posedge clk);
			if (frame.valid && frame.ready) begin
				got = mkf(frame.tan_x, frame.tan_y, frame.tan_z, frame.bitan_x, frame.bitan_y,
					frame.bitan_z, frame.norm_x, frame.norm_y, frame.norm_z,
					frame.uv_degenerate, frame.area_degenerate);
				if (frames_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("Unexpected frame beat");
				end else begin
					e = frames_due.pop_front();
					for (int i = 0; i < 3; i++) begin
						if (got.t[i] !== e.t[i]) report("tangent", e.t[i], got.t[i]);
						if (got.b[i] !== e.b[i]) report("bitangent", e.b[i], got.b[i]);
						if (got.n[i] !== e.n[i]) report("normal", e.n[i], got.n[i]);
					end
					if (got.uvd !== e.uvd) report("uv_degenerate", 16'(e.uvd), 16'(got.uvd));
					if (got.ard !== e.ard) report("area_degenerate", 16'(e.ard), 16'(got.ard));
				end
				frames_seen++;
			end
		end
	end

	// Stimulus: directed table first, then random triangles.
	initial begin
		row_t    dir[$];
		row_t    r;
		frame_t  e;
		vertex_t a, b, c;
		localparam logic [31:0] ONE = 32'h0001_0000;
		localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
		localparam logic [31:0] PMIN = 32'h8000_0000;
		localparam logic [17:0] UONE = 18'h1_0000;
		localparam logic [17:0] UMAX = 18'h1_FFFF;
		localparam logic [17:0] UMIN = 18'h2_0000;
		localparam logic [15:0] P1 = 16'h4000;
		localparam logic [15:0] M1 = 16'hC000;

		vtx.valid = 1'b0;
		vtx.pos_x = '0; vtx.pos_y = '0; vtx.pos_z = '0;
		vtx.tex_u = '0; vtx.tex_v = '0;
		held_a = mk(0, 0, 0, 0, 0);
		held_b = held_a;
		vtx_count = 0;

		// unit right triangle in the xy plane with matching UVs
		dir.push_back('{mk(0, 0, 0, 0, 0), 0, e});
		dir.push_back('{mk(ONE, 0, 0, UONE, 0), 0, e});
		dir.push_back('{mk(0, ONE, 0, 0, UONE), 1, mkf(P1, 0, 0, 0, P1, 0, 0, 0, P1, 0, 0)});
		// mirrored UV: negative determinant flips tangent and bitangent
		dir.push_back('{mk(0, 0, 0, 0, 0), 0, e});
		dir.push_back('{mk(ONE, 0, 0, 0, UONE), 0, e});
		dir.push_back('{mk(0, ONE, 0, UONE, 0), 1, mkf(0, P1, 0, P1, 0, 0, 0, 0, P1, 0, 0)});
		// all-zero UVs and a collapsed triangle: both flags
		dir.push_back('{mk(5, 5, 5, 0, 0), 0, e});
		dir.push_back('{mk(5, 5, 5, 0, 0), 0, e});
		dir.push_back('{mk(5, 5, 5, 0, 0), 1, mkf(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1)});
		// collinear edges with good UVs: zero area only
		dir.push_back('{mk(0, 0, 0, 0, 0), 0, e});
		dir.push_back('{mk(ONE, 0, 0, UONE, 0), 0, e});
		dir.push_back('{mk(2 * ONE, 0, 0, 0, UONE), 0, e});
		// extreme positions and UVs
		dir.push_back('{mk(PMIN, PMIN, PMIN, UMIN, UMIN), 0, e});
		dir.push_back('{mk(PMAX, PMIN, PMAX, UMAX, UMIN), 0, e});
		dir.push_back('{mk(PMIN, PMAX, PMAX, UMIN, UMAX), 0, e});
		dir.push_back('{mk(PMAX, PMAX, PMAX, UMAX, UMAX), 0, e});
		dir.push_back('{mk(PMIN, PMIN, PMAX, UMIN, UMAX), 0, e});
		dir.push_back('{mk(PMAX, PMAX, PMIN, UMAX, UMIN), 0, e});
		// tiny triangle in the yz plane, normal along -x
		dir.push_back('{mk(0, 0, 0, 0, 0), 0, e});
		dir.push_back('{mk(0, 0, 1, 1, 0), 0, e});
		dir.push_back('{mk(0, 1, 0, 0, 1), 1, mkf(0, 0, P1, 0, P1, 0, M1, 0, 0, 0, 0)});

		#1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir[i]) begin
			r = dir[i];
			send(r.v);
			// typed-in result replaces the predicted one, so the table is checked too
			if (r.has_exp) begin
				void'(frames_due.pop_back());
				frames_due.push_back(r.exp);
			end
		end

		for (int t = 0; t < RAND_TRIS; t++) begin
			if (t == RAND_TRIS - 30) calm = 1'b1;
			case ($urandom_range(0, 9))
				0: send(rnd_vertex());
				1: begin
					// shared-UV or coincident-vertex degenerate triangle
					a = rnd_vertex(); b = rnd_vertex(); c = rnd_vertex();
					if ($urandom_range(0, 1)) begin
						b.u = a.u; b.v = a.v;
					end else
						c = a;
					send(a); send(b); send(c);
				end
				default: begin
					send(rnd_vertex()); send(rnd_vertex()); send(rnd_vertex());
				end
			endcase
		end
		// close any partial triangle
		while (vtx_count != 0) send(rnd_vertex());
		vtx.valid <= 1'b0;
		drive_done = 1'b1;
	end

	// End of run: drain, let the back end settle, then report.
	initial begin
		wait (drive_done);
		while (frames_due.size() != 0) @(posedge clk);
		repeat (800) @(posedge clk);
		$display("Sent %0d vertex beats, checked %0d frame beats, %0d mismatches.",
			vtx_sent, frames_seen, mismatches);
		if (mismatches == 0 && frames_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3000000;
		$display("Timeout with %0d frame beats outstanding", frames_due.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
